// ===== rtl/dtl_pkg.sv =====
// ----------------------------------------------------------------------------
// dtl_pkg
// Shared types, constants and arithmetic helpers of the dense tanh layer.
// ----------------------------------------------------------------------------
package dtl_pkg;

    localparam int MAX_IN  = 32;
    localparam int MAX_OUT = 32;
    localparam int RES_CAP = 32;

    localparam int IN_CAP  = (MAX_IN  < RES_CAP) ? MAX_IN  : RES_CAP;
    localparam int OUT_CAP = (MAX_OUT < RES_CAP) ? MAX_OUT : RES_CAP;

    localparam int IN_AW   = $clog2(MAX_IN);
    localparam int OUT_AW  = $clog2(MAX_OUT);
    localparam int W_DEPTH = MAX_IN * MAX_OUT;
    localparam int W_AW    = $clog2(W_DEPTH);

    localparam int CNT_W   = 6;
    localparam int ACC_W   = 40;
    localparam int RND_W   = ACC_W - 12;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(32);
    localparam logic signed [15:0] BIAS_INIT = 16'sd410;
    localparam int ONE_Q = 4096;

    localparam logic [2:0] OP_WR_W  = 3'd0;
    localparam logic [2:0] OP_WR_B  = 3'd1;
    localparam logic [2:0] OP_FWD   = 3'd2;
    localparam logic [2:0] OP_GRAD  = 3'd3;
    localparam logic [2:0] OP_RD_WG = 3'd4;
    localparam logic [2:0] OP_RD_BG = 3'd5;

    localparam logic [1:0] KIND_ACT = 2'd0;
    localparam logic [1:0] KIND_IG  = 2'd1;
    localparam logic [1:0] KIND_WG  = 2'd2;
    localparam logic [1:0] KIND_BG  = 2'd3;

    localparam logic CFG_IN_COUNT  = 1'b0;
    localparam logic CFG_OUT_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]        op;
        logic [4:0]        row;
        logic [4:0]        col;
        logic signed [15:0] value;
        logic              last;
    } dtl_in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [4:0]        index;
        logic signed [15:0] value_res;
        logic              last_res;
    } dtl_out_t;

    // round half up back to Q3.12
    function automatic logic signed [RND_W-1:0] rnd12(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + $signed(ACC_W'(2048));
        return t[ACC_W-1:12];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [RND_W-1:0] v);
        if (v > $signed(RND_W'(32767)))
            return 16'sh7fff;
        else if (v < -$signed(RND_W'(32768)))
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r, input int cap);
        if (r == '0)
            return CNT_W'(1);
        else if (int'(r) > cap)
            return CNT_W'(cap);
        else
            return r;
    endfunction

    // tanh(k/8) in Q3.12, entries past the end hold the top value
    function automatic logic [11:0] tanh_tab(input logic [5:0] k);
        case (k)
            6'd0:  return 12'd0;
            6'd1:  return 12'd509;
            6'd2:  return 12'd1003;
            6'd3:  return 12'd1468;
            6'd4:  return 12'd1893;
            6'd5:  return 12'd2272;
            6'd6:  return 12'd2602;
            6'd7:  return 12'd2883;
            6'd8:  return 12'd3119;
            6'd9:  return 12'd3315;
            6'd10: return 12'd3475;
            6'd11: return 12'd3604;
            6'd12: return 12'd3707;
            6'd13: return 12'd3790;
            6'd14: return 12'd3856;
            6'd15: return 12'd3908;
            6'd16: return 12'd3949;
            6'd17: return 12'd3981;
            6'd18: return 12'd4006;
            6'd19: return 12'd4026;
            6'd20: return 12'd4041;
            6'd21: return 12'd4053;
            6'd22: return 12'd4063;
            6'd23: return 12'd4070;
            6'd24: return 12'd4076;
            6'd25: return 12'd4080;
            6'd26: return 12'd4084;
            6'd27: return 12'd4086;
            6'd28: return 12'd4089;
            6'd29: return 12'd4090;
            6'd30: return 12'd4091;
            6'd31: return 12'd4092;
            default: return 12'd4093;
        endcase
    endfunction

endpackage

// ===== rtl/dtl_tanh.sv =====
// ----------------------------------------------------------------------------
// dtl_tanh
// Table tanh with linear interpolation over a Q3.12 input clamped to +-4.
// ----------------------------------------------------------------------------
module dtl_tanh (
    input  logic signed [15:0] z,
    output logic signed [15:0] y
);
    import dtl_pkg::*;

    logic [15:0] mag;
    logic [5:0]  idx;
    logic [8:0]  frac;
    logic [11:0] base;
    logic [11:0] nxt;
    logic [21:0] step;
    logic [12:0] mag_y;

    always_comb
    begin
        mag   = z[15] ? 16'(-z) : 16'(z);
        idx   = mag[14:9];
        frac  = mag[8:0];
        base  = tanh_tab(idx);
        nxt   = tanh_tab(idx + 6'd1);
        // table is monotonic so the slope is never negative
        step  = 22'(nxt - base) * 22'(frac) + 22'd256;
        mag_y = 13'(base) + 13'(step[21:9]);
        y     = z[15] ? -$signed({3'b000, mag_y}) : $signed({3'b000, mag_y});
    end

endmodule

// ===== rtl/dtl_result_reg.sv =====
// ----------------------------------------------------------------------------
// dtl_result_reg
// Output register holding one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module dtl_result_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  dtl_pkg::dtl_out_t   load_data,
    output logic                free,
    output logic                result_valid,
    input  logic                result_ready,
    output dtl_pkg::dtl_out_t   result
);
    import dtl_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    dtl_out_t data_reg;

    assign free         = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

endmodule

// ===== rtl/dense_tanh_layer_unit.sv =====
// ----------------------------------------------------------------------------
// dense_tanh_layer_unit
// Fully connected tanh layer, forward and backward, Q3.12, one shared MAC.
// ----------------------------------------------------------------------------
// After reset the weight-gradient memory is swept to zero, one entry a cycle
// over all MAX_IN*MAX_OUT = 1024 entries, before the first item is taken. Loads,
// stream elements without last and bias-gradient reads are done in the idle
// state; a weight-gradient read adds a state for the memory read. Forward and
// backward vectors run row by row, one multiply-accumulate per cycle within a
// row, through the single read port of the weight memory; each result beat
// waits for the consumer before the next row or beat starts.
module dense_tanh_layer_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  dtl_pkg::dtl_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output dtl_pkg::dtl_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [5:0]        cfg_data
);
    import dtl_pkg::*;

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_RDWG    = 5'd2;
    localparam logic [4:0] S_F_PREP  = 5'd3;
    localparam logic [4:0] S_F_ISSUE = 5'd4;
    localparam logic [4:0] S_F_DRAIN = 5'd5;
    localparam logic [4:0] S_F_ROUND = 5'd6;
    localparam logic [4:0] S_F_OUT   = 5'd7;
    localparam logic [4:0] S_B_PREP  = 5'd8;
    localparam logic [4:0] S_B_SQ    = 5'd9;
    localparam logic [4:0] S_B_DER   = 5'd10;
    localparam logic [4:0] S_B_MUL   = 5'd11;
    localparam logic [4:0] S_B_BG    = 5'd12;
    localparam logic [4:0] S_B_ISSUE = 5'd13;
    localparam logic [4:0] S_B_DRAIN = 5'd14;
    localparam logic [4:0] S_G_READ  = 5'd15;
    localparam logic [4:0] S_G_OUT   = 5'd16;

    function automatic logic [W_AW-1:0] waddr(input logic [OUT_AW-1:0] r,
                                              input logic [IN_AW-1:0] c);
        return W_AW'(r) * W_AW'(MAX_IN) + W_AW'(c);
    endfunction

    // control
    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [W_AW-1:0]  clr_reg, clr_next;
    logic             bwd_reg, bwd_next;
    logic [CNT_W-1:0] in_count_reg, out_count_reg;
    logic [CNT_W-1:0] ni, no;
    logic             accept, row_ok, col_ok;
    logic             issue;
    logic             v1_reg, v2_reg;
    logic [CNT_W-1:0] j1_reg, j2_reg;

    // datapath
    logic signed [15:0]      w_rd_reg, x_rd_reg, act_rd_reg, gin_rd_reg, wg_rd_reg;
    logic signed [ACC_W-1:0] gacc_rd_reg;
    logic signed [31:0]      prod_reg, px_reg, sq_reg, gp_reg;
    logic signed [ACC_W-1:0] gold_reg, acc_reg;
    logic signed [15:0]      g_reg, der_reg, bg_reg, z_reg;
    logic signed [RND_W-1:0] z_rnd;
    logic signed [15:0]      act_y;
    logic signed [15:0]      bias_reg [MAX_OUT];
    logic signed [15:0]      bgrad_reg [MAX_OUT];
    logic [4:0]              rd_col_reg;
    logic                    rd_ok_reg;

    // memories
    logic signed [15:0]      w_mem [W_DEPTH];
    logic signed [15:0]      wg_mem [W_DEPTH];
    logic signed [15:0]      x_mem [MAX_IN];
    logic signed [15:0]      act_mem [MAX_OUT];
    logic signed [15:0]      gin_mem [MAX_OUT];
    logic signed [ACC_W-1:0] gacc_mem [MAX_IN];

    logic                    wg_we, gacc_we, act_we;
    logic [W_AW-1:0]         wg_waddr;
    logic signed [15:0]      wg_wdata;

    logic     res_load, res_free;
    dtl_out_t res_data;

    assign ni        = eff_count(in_count_reg, IN_CAP);
    assign no        = eff_count(out_count_reg, OUT_CAP);
    assign row_ok    = int'(item.row) < MAX_OUT;
    assign col_ok    = int'(item.col) < MAX_IN;
    assign item_ready = (state_reg == S_IDLE) && res_free;
    assign accept    = item_valid && item_ready;
    assign cfg_ready = 1'b1;
    assign issue     = (state_reg == S_F_ISSUE) || (state_reg == S_B_ISSUE);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= COUNT_RESET;
            out_count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IN_COUNT:  in_count_reg  <= cfg_data;
                CFG_OUT_COUNT: out_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        clr_next   = clr_reg;
        bwd_next   = bwd_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + W_AW'(1);
                if (int'(clr_reg) == W_DEPTH - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    i_next = '0;
                    j_next = '0;
                    case (item.op)
                        OP_FWD:
                        begin
                            if (item.last)
                            begin
                                bwd_next   = 1'b0;
                                state_next = S_F_PREP;
                            end
                        end
                        OP_GRAD:
                        begin
                            if (item.last)
                            begin
                                bwd_next   = 1'b1;
                                state_next = S_B_PREP;
                            end
                        end
                        OP_RD_WG: state_next = S_RDWG;
                        default: ;
                    endcase
                end
            end
            S_RDWG:    state_next = S_IDLE;
            S_F_PREP:
            begin
                j_next     = '0;
                state_next = S_F_ISSUE;
            end
            S_F_ISSUE, S_B_ISSUE:
            begin
                if (j_reg == ni - CNT_W'(1))
                    state_next = (state_reg == S_F_ISSUE) ? S_F_DRAIN : S_B_DRAIN;
                else
                    j_next = j_reg + CNT_W'(1);
            end
            S_F_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = S_F_ROUND;
            end
            S_F_ROUND: state_next = S_F_OUT;
            S_F_OUT:
            begin
                if (res_free)
                begin
                    if (i_reg == no - CNT_W'(1))
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_F_PREP;
                    end
                end
            end
            S_B_PREP:  state_next = S_B_SQ;
            S_B_SQ:    state_next = S_B_DER;
            S_B_DER:   state_next = S_B_MUL;
            S_B_MUL:   state_next = S_B_BG;
            S_B_BG:
            begin
                j_next     = '0;
                state_next = S_B_ISSUE;
            end
            S_B_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    if (i_reg == no - CNT_W'(1))
                    begin
                        j_next     = '0;
                        state_next = S_G_READ;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_B_PREP;
                    end
                end
            end
            S_G_READ:  state_next = S_G_OUT;
            S_G_OUT:
            begin
                if (res_free)
                begin
                    if (j_reg == ni - CNT_W'(1))
                        state_next = S_IDLE;
                    else
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = S_G_READ;
                    end
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            i_reg     <= '0;
            j_reg     <= '0;
            clr_reg   <= '0;
            bwd_reg   <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            clr_reg   <= clr_next;
            bwd_reg   <= bwd_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
        end
    end

    // bias and bias-gradient registers reset to 0.1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_OUT; k++)
            begin
                bias_reg[k]  <= BIAS_INIT;
                bgrad_reg[k] <= BIAS_INIT;
            end
        end
        else
        begin
            if (accept && item.op == OP_WR_B && row_ok)
                bias_reg[item.row[OUT_AW-1:0]] <= item.value;
            if (state_reg == S_B_BG)
                bgrad_reg[i_reg[OUT_AW-1:0]] <= sat16(rnd12(ACC_W'(gp_reg)));
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (accept && item.op == OP_WR_W && row_ok && col_ok)
            w_mem[waddr(item.row[OUT_AW-1:0], item.col[IN_AW-1:0])] <= item.value;
        w_rd_reg <= w_mem[waddr(i_reg[OUT_AW-1:0], j_reg[IN_AW-1:0])];
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.op == OP_FWD && col_ok)
            x_mem[item.col[IN_AW-1:0]] <= item.value;
        x_rd_reg <= x_mem[j_reg[IN_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.op == OP_GRAD && row_ok)
            gin_mem[item.row[OUT_AW-1:0]] <= item.value;
        gin_rd_reg <= gin_mem[i_reg[OUT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (act_we)
            act_mem[i_reg[OUT_AW-1:0]] <= act_y;
        act_rd_reg <= act_mem[i_reg[OUT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (gacc_we)
            gacc_mem[j2_reg[IN_AW-1:0]] <= gold_reg + ACC_W'(prod_reg);
        gacc_rd_reg <= gacc_mem[j_reg[IN_AW-1:0]];
    end

    always_comb
    begin
        wg_we    = 1'b0;
        wg_waddr = waddr(i_reg[OUT_AW-1:0], j2_reg[IN_AW-1:0]);
        wg_wdata = sat16(rnd12(ACC_W'(px_reg)));
        if (state_reg == S_CLEAR)
        begin
            wg_we    = 1'b1;
            wg_waddr = clr_reg;
            wg_wdata = '0;
        end
        else if (v2_reg && bwd_reg)
            wg_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wg_we)
            wg_mem[wg_waddr] <= wg_wdata;
        wg_rd_reg <= wg_mem[waddr(item.row[OUT_AW-1:0], item.col[IN_AW-1:0])];
    end

    assign gacc_we = v2_reg && bwd_reg;
    assign act_we  = (state_reg == S_F_OUT) && res_free;

    // mac pipeline: read, multiply, accumulate
    always_ff @(posedge clk)
    begin
        j1_reg <= j_reg;
        j2_reg <= j1_reg;
        if (v1_reg)
        begin
            prod_reg <= (bwd_reg ? bg_reg : x_rd_reg) * w_rd_reg;
            px_reg   <= bg_reg * x_rd_reg;
            // first row starts the input-gradient sums from zero
            gold_reg <= (i_reg == '0) ? '0 : gacc_rd_reg;
        end
        if (state_reg == S_F_PREP)
            acc_reg <= ACC_W'(bias_reg[i_reg[OUT_AW-1:0]]) <<< 12;
        else if (v2_reg && !bwd_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // backward per-neuron chain
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_B_SQ:
            begin
                sq_reg <= act_rd_reg * act_rd_reg;
                g_reg  <= gin_rd_reg;
            end
            S_B_DER: der_reg <= 16'(RND_W'(ONE_Q) - rnd12(ACC_W'(sq_reg)));
            S_B_MUL: gp_reg  <= g_reg * der_reg;
            S_B_BG:  bg_reg  <= sat16(rnd12(ACC_W'(gp_reg)));
            default: ;
        endcase
    end

    // pre-activation clamped to +-4.0
    assign z_rnd = rnd12(acc_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_F_ROUND)
        begin
            if (z_rnd > $signed(RND_W'(16384)))
                z_reg <= 16'sd16384;
            else if (z_rnd < -$signed(RND_W'(16384)))
                z_reg <= -16'sd16384;
            else
                z_reg <= z_rnd[15:0];
        end
        if (accept)
        begin
            rd_col_reg <= item.col;
            rd_ok_reg  <= row_ok && col_ok;
        end
    end

    dtl_tanh u_tanh (
        .z (z_reg),
        .y (act_y)
    );

    // result beat source
    always_comb
    begin
        res_load = 1'b0;
        res_data = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.op == OP_RD_BG)
                begin
                    res_load           = 1'b1;
                    res_data.kind      = KIND_BG;
                    res_data.index     = item.row;
                    res_data.value_res = row_ok ? bgrad_reg[item.row[OUT_AW-1:0]] : '0;
                    res_data.last_res  = 1'b1;
                end
            end
            S_RDWG:
            begin
                res_load           = 1'b1;
                res_data.kind      = KIND_WG;
                res_data.index     = rd_col_reg;
                res_data.value_res = rd_ok_reg ? wg_rd_reg : '0;
                res_data.last_res  = 1'b1;
            end
            S_F_OUT:
            begin
                res_load           = res_free;
                res_data.kind      = KIND_ACT;
                res_data.index     = 5'(i_reg);
                res_data.value_res = act_y;
                res_data.last_res  = (i_reg == no - CNT_W'(1));
            end
            S_G_OUT:
            begin
                res_load           = res_free;
                res_data.kind      = KIND_IG;
                res_data.index     = 5'(j_reg);
                res_data.value_res = sat16(rnd12(gacc_rd_reg));
                res_data.last_res  = (j_reg == ni - CNT_W'(1));
            end
            default: ;
        endcase
    end

    dtl_result_reg u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_load),
        .load_data    (res_data),
        .free         (res_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== rtl/dtl_checker.sv =====
// ----------------------------------------------------------------------------
// dtl_checker
// Port-level checks of the dense tanh layer, bound to the top level.
// ----------------------------------------------------------------------------
module dtl_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  dtl_pkg::dtl_in_t  item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  dtl_pkg::dtl_out_t result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [5:0]        cfg_data
);
    import dtl_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // a bias-gradient read answers in the next cycle as a single beat
    a_bg_read: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.op == OP_RD_BG
        |=> result_valid && result.kind == KIND_BG && result.last_res)
        else $error("bias gradient read not answered");

    // a vector run closes the input side once its last element is taken
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.last && (item.op == OP_FWD || item.op == OP_GRAD)
        |=> !item_ready)
        else $error("input taken during a vector run");

    // weight-gradient reads are always the last beat of their run
    a_wg_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_WG |-> result.last_res)
        else $error("weight gradient beat without last");

endmodule

bind dense_tanh_layer_unit dtl_checker u_dtl_checker (.*);
